// File: design/implicit_bst_forest_search_unit_defines.svh
// Assertion helpers for the forest search unit.
`ifndef IMPLICIT_BST_FOREST_SEARCH_UNIT_DEFINES_SVH
`define IMPLICIT_BST_FOREST_SEARCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define IBFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibfs assertion failed");
// Next-cycle implication.
`define IBFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibfs assertion failed");
`else
`define IBFS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define IBFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: design/ibfs_pkg.sv
`timescale 1ns / 1ps
package ibfs_pkg;

    localparam int CNT_W  = 13;
    localparam int ADDR_W = 12;
    localparam int KEY_W  = 32;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                     search;
        logic                     wr_ok;
        logic [ADDR_W-1:0]        addr;
        logic signed [KEY_W-1:0]  key;
    } t_item;

    // Largest 2^k-1 not above rem: mask below the top set bit of rem+1.
    function automatic logic [CNT_W-1:0] largest_perfect(input logic [CNT_W-1:0] rem);
        logic [CNT_W:0] v;
        logic [CNT_W:0] s;
        v = {1'b0, rem} + (CNT_W+1)'(1);
        s = '0;
        for (int i = 0; i < CNT_W + 1; i++) begin
            if (v[i]) s = (CNT_W+1)'((1 << i) - 1);
        end
        return s[CNT_W-1:0];
    endfunction

endpackage

// File: design/ibfs_ram.sv
`timescale 1ns / 1ps
module ibfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ibfs_front.sv
`timescale 1ns / 1ps
module ibfs_front #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_op,
    input  logic [ibfs_pkg::ADDR_W-1:0]     i_address,
    input  logic signed [ibfs_pkg::KEY_W-1:0] i_key,
    output logic                            o_q_valid,
    output ibfs_pkg::t_item                 o_q_item,
    input  logic                            i_q_pop
);
    import ibfs_pkg::*;

    t_item       r_mem [2];
    logic        r_wptr, n_wptr;
    logic        r_rptr, n_rptr;
    logic [1:0]  r_count, n_count;
    logic        push;
    logic        pop;
    t_item       item;

    // classify: searches pass as is, writes outside the store are marked dead
    always_comb begin
        item.search = (i_op == OP_SEARCH);
        item.wr_ok  = (32'(i_address) < 32'(STORE_DEPTH));
        item.addr   = i_address;
        item.key    = i_key;
    end

    assign o_in_ready = (r_count != 2'd2);
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_q_pop && (r_count != 2'd0);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = push ? !r_wptr : r_wptr;
        n_rptr  = pop  ? !r_rptr : r_rptr;
        n_count = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// File: design/ibfs_engine.sv
`timescale 1ns / 1ps
`include "implicit_bst_forest_search_unit_defines.svh"
module ibfs_engine #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ibfs_pkg::CNT_W-1:0]  i_total,
    input  logic                        i_q_valid,
    input  ibfs_pkg::t_item             i_q_item,
    output logic                        o_q_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_found
);
    import ibfs_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TREE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_rem, n_rem;
    logic [CNT_W-1:0]        r_base, n_base;
    logic [CNT_W-1:0]        r_size, n_size;
    logic [CNT_W-1:0]        r_j, n_j;
    logic                    r_hit, n_hit;
    logic                    r_out_valid, n_out_valid;
    logic                    r_found, n_found;
    logic                    key_load;
    logic signed [KEY_W-1:0] r_key;

    logic [CNT_W-1:0]        sat_total;
    logic [CNT_W:0]          nj;
    logic [CNT_W-1:0]        idx;
    logic [CNT_W-1:0]        rem_after;
    logic [AW+CNT_W-1:0]     raddr_ext;
    logic [AW+ADDR_W-1:0]    waddr_ext;
    logic                    ram_we;
    logic                    ram_re;
    logic [KEY_W-1:0]        ram_rdata;
    logic signed [KEY_W-1:0] node;

    assign sat_total = (32'(i_total) > 32'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH) : i_total;
    assign idx       = r_base + r_j;
    assign raddr_ext = {AW'(0), idx};
    assign waddr_ext = {AW'(0), i_q_item.addr};
    assign node      = signed'(ram_rdata);
    assign rem_after = r_rem - r_size;
    assign nj        = (node > r_key) ? ({r_j, 1'b0} + (CNT_W+1)'(1))
                                      : ({r_j, 1'b0} + (CNT_W+1)'(2));

    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    assign ram_we    = o_q_pop && !i_q_item.search && i_q_item.wr_ok;
    assign ram_re    = (r_state == S_RD);

    ibfs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr_ext[AW-1:0]),
        .i_wdata (i_q_item.key),
        .i_re    (ram_re),
        .i_raddr (raddr_ext[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_base      = r_base;
        n_size      = r_size;
        n_j         = r_j;
        n_hit       = r_hit;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_out_ready;
        key_load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && i_q_item.search) begin
                    key_load = 1'b1;
                    n_rem    = sat_total;
                    n_base   = '0;
                    n_hit    = 1'b0;
                    n_state  = (sat_total == '0) ? S_DONE : S_TREE;
                end
            end
            S_TREE: begin
                n_size  = largest_perfect(r_rem);
                n_j     = '0;
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (node == r_key) begin
                    n_hit   = 1'b1;
                    n_state = S_DONE;
                end else if (nj < {1'b0, r_size}) begin
                    n_j     = nj[CNT_W-1:0];
                    n_state = S_RD;
                end else begin
                    // leaf passed: move on to the next tree
                    n_base  = r_base + r_size;
                    n_rem   = rem_after;
                    n_state = (rem_after == '0) ? S_DONE : S_TREE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_found     = r_hit;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_base  <= n_base;
        r_size  <= n_size;
        r_j     <= n_j;
        r_hit   <= n_hit;
        r_found <= n_found;
        if (key_load) begin
            r_key <= i_q_item.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;

    `IBFS_ASSERT_NOW(a_no_write_in_search, i_clk, i_rst_n, r_state != S_IDLE, !ram_we)
    `IBFS_ASSERT_NOW(a_node_in_tree, i_clk, i_rst_n, r_state == S_RD, r_j < r_size)
    `IBFS_ASSERT_NEXT(a_read_then_cmp, i_clk, i_rst_n, r_state == S_RD, r_state == S_CMP)
    `IBFS_ASSERT_NOW(a_probe_in_range, i_clk, i_rst_n, r_state == S_RD,
                     32'(idx) < 32'(STORE_DEPTH))

endmodule

// File: design/implicit_bst_forest_search_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake                 Payload
// in       in   i_in_valid / o_in_ready   i_op, i_address, i_key
// out      out  o_out_valid / i_out_ready o_found
// cfg      in   i_cfg_we                  i_cfg_wdata (total_entries)
//
// A write is stored in the key store as the engine pops it. A search walks
// each tree in turn: S_TREE sizes the tree, S_RD and S_CMP read and compare
// one node at a time on the single RAM read port, and S_DONE posts the result.
// Synchronous active-low reset clears the queue, engine state, output valid
// and total_entries; the key store is not cleared.
// A two-entry queue lets input transfers continue while a search runs or a
// result waits at the output register.
module implicit_bst_forest_search_unit #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic [ibfs_pkg::ADDR_W-1:0]       i_address,
    input  logic signed [ibfs_pkg::KEY_W-1:0] i_key,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    input  logic                              i_cfg_we,
    input  logic [ibfs_pkg::CNT_W-1:0]        i_cfg_wdata
);
    import ibfs_pkg::*;

    logic [CNT_W-1:0] r_total;
    logic             q_valid;
    t_item            q_item;
    logic             q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cfg_we) begin
            r_total <= i_cfg_wdata;
        end
    end

    ibfs_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_address  (i_address),
        .i_key      (i_key),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    ibfs_engine #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_total     (r_total),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_found     (o_found)
    );

endmodule
